>>> hw/rtl/ipa_phone_tokenizer_top_assert.svh
// ----------------------------------------------------------------------------
// IPA phone tokenizer assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef IPA_PHONE_TOKENIZER_TOP_ASSERT_SVH
`define IPA_PHONE_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define IPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types, constants, rule table and decision function of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ipt_pkg;

  localparam int unsigned PAT_MAX   = 4;   // longest rule pattern, window depth
  localparam int unsigned IDX_W     = $clog2(PAT_MAX);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned CODE_W    = 6;
  localparam int unsigned NTOK_W    = 2;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned NUM_RULES = 42;
  localparam logic [CODE_W-1:0] MAX_CODE = 6'd37;

  localparam int unsigned DEC_QUEUE_DEPTH = 2;
  localparam int unsigned OUT_QUEUE_DEPTH = 2;

  // UTF-8 lead byte classes
  localparam logic [7:0] UTF8_ASCII_LIM = 8'h80;
  localparam logic [2:0] UTF8_LEAD2     = 3'h6;
  localparam logic [3:0] UTF8_LEAD3     = 4'hE;
  localparam logic [4:0] UTF8_LEAD4     = 5'h1E;

  typedef logic [PAT_MAX-1:0][7:0] win_t;   // [0] is the window head

  typedef struct packed {
    logic [CNT_W-1:0]  len;
    logic [31:0]       pat;    // first byte in the top byte
    logic [NTOK_W-1:0] nemit;
    logic [CODE_W-1:0] e0;
    logic [CODE_W-1:0] e1;
  } rule_t;

  typedef struct packed {
    logic [CNT_W-1:0]  used;
    logic [NTOK_W-1:0] ntok;
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
  } dec_res_t;

  // front -> back request
  typedef struct packed {
    logic [NTOK_W-1:0] ntok;
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
    logic              done;   // last request of the end-of-text drain
    logic              drain;  // belongs to the end-of-text drain
  } dec_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              valid;
    logic              done;
  } out_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } direct_t;

  localparam rule_t RULES [NUM_RULES] = '{
    '{3'd3, 32'h65C9AA00, 2'd2, 6'd0,  6'd1},
    '{3'd4, 32'hC991C9AA, 2'd2, 6'd2,  6'd1},
    '{3'd3, 32'h61C9AA00, 2'd2, 6'd2,  6'd1},
    '{3'd4, 32'hC991CA8A, 2'd2, 6'd2,  6'd3},
    '{3'd3, 32'h61CA8A00, 2'd2, 6'd2,  6'd3},
    '{3'd4, 32'hC994C9AA, 2'd2, 6'd4,  6'd1},
    '{3'd3, 32'h6FCA8A00, 2'd2, 6'd5,  6'd3},
    '{3'd4, 32'hC999CA8A, 2'd2, 6'd5,  6'd3},
    '{3'd3, 32'h74CA8300, 2'd2, 6'd6,  6'd7},
    '{3'd3, 32'h64CA9200, 2'd2, 6'd8,  6'd9},
    '{3'd2, 32'hCB900000, 2'd0, 6'd0,  6'd0},
    '{3'd2, 32'hCB880000, 2'd1, 6'd10, 6'd0},
    '{3'd2, 32'hCB8C0000, 2'd1, 6'd11, 6'd0},
    '{3'd2, 32'hC9A10000, 2'd1, 6'd12, 6'd0},
    '{3'd2, 32'hC99A0000, 2'd1, 6'd13, 6'd0},
    '{3'd2, 32'hC9980000, 2'd1, 6'd14, 6'd0},
    '{3'd2, 32'hC9900000, 2'd1, 6'd15, 6'd0},
    '{3'd2, 32'hC99C0000, 2'd1, 6'd13, 6'd0},
    '{3'd2, 32'hC9920000, 2'd1, 6'd4,  6'd0},
    '{3'd2, 32'hC9BE0000, 2'd1, 6'd8,  6'd0},
    '{3'd2, 32'hC9AA0000, 2'd1, 6'd1,  6'd0},
    '{3'd2, 32'hC99B0000, 2'd1, 6'd16, 6'd0},
    '{3'd2, 32'hC3A60000, 2'd1, 6'd17, 6'd0},
    '{3'd2, 32'hC9910000, 2'd1, 6'd2,  6'd0},
    '{3'd2, 32'hC9940000, 2'd1, 6'd4,  6'd0},
    '{3'd2, 32'hCA8A0000, 2'd1, 6'd3,  6'd0},
    '{3'd2, 32'hCA8C0000, 2'd1, 6'd15, 6'd0},
    '{3'd2, 32'hC99D0000, 2'd1, 6'd13, 6'd0},
    '{3'd2, 32'hC9990000, 2'd1, 6'd14, 6'd0},
    '{3'd2, 32'hC58B0000, 2'd1, 6'd18, 6'd0},
    '{3'd2, 32'hCEB80000, 2'd1, 6'd19, 6'd0},
    '{3'd2, 32'hC3B00000, 2'd1, 6'd20, 6'd0},
    '{3'd2, 32'hCA830000, 2'd1, 6'd7,  6'd0},
    '{3'd2, 32'hCA920000, 2'd1, 6'd9,  6'd0},
    '{3'd2, 32'hC9B90000, 2'd1, 6'd21, 6'd0},
    '{3'd1, 32'h61000000, 2'd1, 6'd2,  6'd0},
    '{3'd1, 32'h72000000, 2'd1, 6'd21, 6'd0},
    '{3'd1, 32'h79000000, 2'd1, 6'd22, 6'd0},
    '{3'd1, 32'h67000000, 2'd1, 6'd12, 6'd0},
    '{3'd1, 32'h20000000, 2'd1, 6'd23, 6'd0},
    '{3'd1, 32'h09000000, 2'd1, 6'd23, 6'd0},
    '{3'd1, 32'h0A000000, 2'd1, 6'd23, 6'd0}
  };

  function automatic direct_t direct_code(input logic [7:0] b);
    direct_t d;
    d.hit = 1'b1;
    unique case (b)
      8'h69:   d.code = 6'd24;  // i
      8'h65:   d.code = 6'd0;   // e
      8'h6F:   d.code = 6'd5;   // o
      8'h75:   d.code = 6'd25;  // u
      8'h70:   d.code = 6'd26;  // p
      8'h62:   d.code = 6'd27;  // b
      8'h74:   d.code = 6'd6;   // t
      8'h64:   d.code = 6'd8;   // d
      8'h6B:   d.code = 6'd28;  // k
      8'h6D:   d.code = 6'd29;  // m
      8'h6E:   d.code = 6'd30;  // n
      8'h66:   d.code = 6'd31;  // f
      8'h76:   d.code = 6'd32;  // v
      8'h73:   d.code = 6'd33;  // s
      8'h7A:   d.code = 6'd34;  // z
      8'h68:   d.code = 6'd35;  // h
      8'h77:   d.code = 6'd36;  // w
      8'h6A:   d.code = 6'd22;  // j
      8'h6C:   d.code = 6'd37;  // l
      default: begin
        d.hit  = 1'b0;
        d.code = '0;
      end
    endcase
    return d;
  endfunction

  function automatic logic [CNT_W-1:0] utf8_len(input logic [7:0] lead);
    logic [CNT_W-1:0] n;
    priority if (lead < UTF8_ASCII_LIM) n = CNT_W'(1);
    else if (lead[7:5] == UTF8_LEAD2)   n = CNT_W'(2);
    else if (lead[7:4] == UTF8_LEAD3)   n = CNT_W'(3);
    else if (lead[7:3] == UTF8_LEAD4)   n = CNT_W'(4);
    else                                n = CNT_W'(1);  // stray or invalid lead
    return n;
  endfunction

  // One decision at the window head; avail is the number of valid bytes.
  function automatic dec_res_t decide(input win_t win, input logic [CNT_W-1:0] avail);
    dec_res_t res;
    logic     hit;
    logic     match;
    rule_t    rl;
    direct_t  dc;
    res = '0;
    hit = 1'b0;
    for (int r = 0; r < NUM_RULES; r++) begin
      rl    = RULES[r];
      match = (rl.len <= avail);
      for (int k = 0; k < PAT_MAX; k++) begin
        if ((CNT_W'(k) < rl.len) && (win[k] != rl.pat[31-8*k -: 8])) match = 1'b0;
      end
      if (match && !hit) begin
        hit       = 1'b1;
        res.used  = rl.len;
        res.ntok  = rl.nemit;
        res.code0 = rl.e0;
        res.code1 = rl.e1;
      end
    end
    if (!hit) begin
      dc = direct_code(win[0]);
      if (dc.hit) begin
        res.used  = CNT_W'(1);
        res.ntok  = NTOK_W'(1);
        res.code0 = dc.code;
      end else begin
        res.used  = utf8_len(win[0]);
      end
    end
    if (res.used > avail) res.used = avail;  // truncated sequence at the end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ipt_fifo.sv
// ----------------------------------------------------------------------------
// ipt_fifo
// Small register FIFO with first-word fall-through head.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_ok, rd_ok;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign wr_ok   = push_i & ~full_o;
  assign rd_ok   = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr_ok) wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (rd_ok) rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (wr_ok && !rd_ok)      cnt_d = cnt_q + 1'b1;
    else if (rd_ok && !wr_ok) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/ipt_front.sv
// ----------------------------------------------------------------------------
// ipt_front
// Byte intake, lookahead window and rule decision; issues token requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        text_byte_i,
  input  logic              text_end_i,
  output logic              full_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ipt_pkg::dec_t     q_data_o
);

  typedef enum logic {FILL, DRAIN} state_e;

  state_e                      state_q, state_d;
  ipt_pkg::win_t               win_q, win_d, win_app, dec_win, win_shift;
  logic [ipt_pkg::CNT_W-1:0]   cnt_q, cnt_d, cnt_app, dec_avail, cnt_left;
  ipt_pkg::dec_res_t           res;
  logic                        accept;

  assign full_o = (state_q == DRAIN) | q_full_i;
  assign accept = push_i & ~full_o;

  always_comb begin
    win_app = win_q;
    win_app[cnt_q[ipt_pkg::IDX_W-1:0]] = text_byte_i;
    cnt_app = cnt_q + 1'b1;
    // drain works on the stored window, normal intake on the appended one
    dec_win   = (state_q == DRAIN) ? win_q : win_app;
    dec_avail = (state_q == DRAIN) ? cnt_q : ipt_pkg::CNT_W'(ipt_pkg::PAT_MAX);
    res       = ipt_pkg::decide(dec_win, dec_avail);
    win_shift = ipt_pkg::win_t'(dec_win >> {res.used, 3'b000});
    cnt_left  = cnt_q - res.used;
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    win_d          = win_q;
    q_push_o       = 1'b0;
    q_data_o.ntok  = res.ntok;
    q_data_o.code0 = res.code0;
    q_data_o.code1 = res.code1;
    q_data_o.done  = 1'b0;
    q_data_o.drain = 1'b0;
    unique case (state_q)
      FILL: begin
        if (accept) begin
          priority if (text_end_i) begin
            win_d   = win_app;
            cnt_d   = cnt_app;
            state_d = DRAIN;
          end else if (cnt_app == ipt_pkg::CNT_W'(ipt_pkg::PAT_MAX)) begin
            win_d    = win_shift;
            cnt_d    = cnt_app - res.used;
            q_push_o = (res.ntok != '0);
          end else begin
            win_d = win_app;
            cnt_d = cnt_app;
          end
        end
      end
      DRAIN: begin
        if (!q_full_i) begin
          q_data_o.drain = 1'b1;
          q_data_o.done  = (cnt_left == '0);
          q_push_o       = (res.ntok != '0) || (cnt_left == '0);
          win_d          = win_shift;
          cnt_d          = cnt_left;
          if (cnt_left == '0) state_d = FILL;
        end
      end
      default: state_d = FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FILL;
      cnt_q   <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      win_q   <= win_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ipt_back.sv
// ----------------------------------------------------------------------------
// ipt_back
// Serializes token requests into result items, one per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  ipt_pkg::dec_t     q_data_i,
  output logic              q_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output ipt_pkg::out_t     out_data_o
);

  logic [ipt_pkg::ACT_W-1:0]  idx_q, idx_d, nact;
  logic                       hold_vld_q, hold_vld_d;
  logic [ipt_pkg::CODE_W-1:0] hold_code_q, hold_code_d, tok_code;
  logic                       is_tok, go, last;

  assign is_tok   = (idx_q < q_data_i.ntok);
  assign tok_code = (idx_q == '0) ? q_data_i.code0 : q_data_i.code1;
  assign nact     = q_data_i.ntok + {1'b0, q_data_i.done};
  assign last     = ((idx_q + 1'b1) == nact);

  // During the drain the newest token is held back, so that the end flag
  // can land on it once the drain turns out to be over.
  always_comb begin
    out_push_o  = 1'b0;
    out_data_o  = '0;
    go          = 1'b0;
    hold_vld_d  = hold_vld_q;
    hold_code_d = hold_code_q;
    if (!q_empty_i) begin
      priority if (is_tok && !q_data_i.drain) begin
        out_push_o       = 1'b1;
        out_data_o.code  = tok_code;
        out_data_o.valid = 1'b1;
        go               = ~out_full_i;
      end else if (is_tok) begin
        if (hold_vld_q) begin
          out_push_o       = 1'b1;
          out_data_o.code  = hold_code_q;
          out_data_o.valid = 1'b1;
          go               = ~out_full_i;
        end else begin
          go = 1'b1;
        end
        if (go) begin
          hold_vld_d  = 1'b1;
          hold_code_d = tok_code;
        end
      end else begin
        // end of text: flagged held token, or bare end marker
        out_push_o       = 1'b1;
        out_data_o.code  = hold_vld_q ? hold_code_q : '0;
        out_data_o.valid = hold_vld_q;
        out_data_o.done  = 1'b1;
        go               = ~out_full_i;
        if (go) hold_vld_d = 1'b0;
      end
    end
    q_pop_o = go & last;
    idx_d   = go ? (last ? '0 : idx_q + 1'b1) : idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      hold_vld_q  <= 1'b0;
      hold_code_q <= '0;
    end else begin
      idx_q       <= idx_d;
      hold_vld_q  <= hold_vld_d;
      hold_code_q <= hold_code_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ipa_phone_tokenizer_top.sv
// ----------------------------------------------------------------------------
// IPA phone tokenizer, top level
// Turns a UTF-8 IPA byte stream into dense phone token codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive text_byte_i/text_end_i with push; a byte is taken
//   on a clock edge with push high and full low. text_end_i marks the last
//   byte of a string. Result side: a token sits on phone_code_o/phone_valid_o/
//   text_done_o while empty is low and is removed by pop.
//   The front keeps a 4-byte window and decides at its head whenever it holds
//   four bytes, the same cycle the byte arrives. A decision yields 0..2
//   tokens, which the back writes out one per cycle while the result queue
//   has room; the first token of a byte passes the request queue, the back
//   and the result queue before it shows on the result ports.
//   Throughput: one byte per cycle while decisions yield at most one token
//   and the receiver keeps up; two-token decisions slow the intake to the
//   back's one token per cycle. A text_end_i byte holds full high while the
//   front drains the window; its last result carries text_done_o, or a lone
//   end marker (phone_valid_o low) is given if the drain emits no token.
//   Reset empties the window and both queues. When the receiver stalls, the
//   result queue fills, then the request queue, then full rises.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipa_phone_tokenizer_top_assert.svh"

module ipa_phone_tokenizer_top #(
  parameter int unsigned DEC_DEPTH = ipt_pkg::DEC_QUEUE_DEPTH,
  parameter int unsigned OUT_DEPTH = ipt_pkg::OUT_QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte intake
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 text_byte_i,
  input  logic                       text_end_i,
  // token results
  output logic                       empty,
  input  logic                       pop,
  output logic [ipt_pkg::CODE_W-1:0] phone_code_o,
  output logic                       phone_valid_o,
  output logic                       text_done_o
);

  localparam int unsigned DecW = $bits(ipt_pkg::dec_t);
  localparam int unsigned OutW = $bits(ipt_pkg::out_t);

  // front -> request queue
  logic            dq_push, dq_full, dq_pop, dq_empty;
  ipt_pkg::dec_t   dq_wdata, dq_rdata;
  logic [DecW-1:0] dq_rbits;

  // back -> result queue
  logic            oq_push, oq_full;
  ipt_pkg::out_t   oq_wdata, oq_rdata;
  logic [OutW-1:0] oq_rbits;

  ipt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .text_byte_i (text_byte_i),
    .text_end_i  (text_end_i),
    .full_o      (full),
    .q_full_i    (dq_full),
    .q_push_o    (dq_push),
    .q_data_o    (dq_wdata)
  );

  // short request queue decouples decisions from token write-out
  ipt_fifo #(
    .WIDTH (DecW),
    .DEPTH (DEC_DEPTH)
  ) u_dec_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dq_push),
    .data_i  (dq_wdata),
    .full_o  (dq_full),
    .pop_i   (dq_pop),
    .data_o  (dq_rbits),
    .empty_o (dq_empty)
  );

  assign dq_rdata = ipt_pkg::dec_t'(dq_rbits);

  ipt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (dq_empty),
    .q_data_i   (dq_rdata),
    .q_pop_o    (dq_pop),
    .out_full_i (oq_full),
    .out_push_o (oq_push),
    .out_data_o (oq_wdata)
  );

  // result queue: a stalled receiver never blocks the back directly
  ipt_fifo #(
    .WIDTH (OutW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_wdata),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (oq_rbits),
    .empty_o (empty)
  );

  assign oq_rdata      = ipt_pkg::out_t'(oq_rbits);
  assign phone_code_o  = oq_rdata.code;
  assign phone_valid_o = oq_rdata.valid;
  assign text_done_o   = oq_rdata.done;

  // an end marker only ever closes a string
  `IPT_ASSERT_NOW(a_marker_is_done, !empty && !phone_valid_o, text_done_o,
                  "end marker without text_done")
  // end marker carries code zero, tokens stay in the code range
  `IPT_ASSERT_NOW(a_code_range, !empty,
                  (phone_valid_o && phone_code_o <= ipt_pkg::MAX_CODE) ||
                  (!phone_valid_o && phone_code_o == '0),
                  "phone code out of range")
  // taking the final byte starts the drain, which holds off the next byte
  `IPT_ASSERT_NEXT(a_end_drains, push && !full && text_end_i, full,
                   "no drain after final byte")

endmodule

`default_nettype wire

>>> test/ipa_phone_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPA phone tokenizer checker
// Watches the byte intake and the token results, predicts the token stream
// from each accepted byte and compares every popped result with it.
// ----------------------------------------------------------------------------
module ipa_phone_tokenizer_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       full,
  input  logic [7:0]                 text_byte_i,
  input  logic                       text_end_i,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [ipt_pkg::CODE_W-1:0] phone_code_o,
  input  logic                       phone_valid_o,
  input  logic                       text_done_o,
  output int                         pending_o,
  output int                         fail_count_o,
  output int                         tokens_o,
  output int                         markers_o,
  output int                         texts_o
);

  typedef enum logic [5:0] {
    PH_E, PH_I_LAX, PH_A_BACK, PH_U_LAX, PH_O_OPEN, PH_O, PH_T, PH_SH, PH_D, PH_ZH,
    PH_STRESS1, PH_STRESS2, PH_G, PH_ER, PH_SCHWA, PH_WEDGE, PH_EPS, PH_ASH, PH_NG,
    PH_TH, PH_DH, PH_R, PH_J, PH_PAUSE, PH_I, PH_U, PH_P, PH_B, PH_K, PH_M, PH_N,
    PH_F, PH_V, PH_S, PH_Z, PH_H, PH_W, PH_L
  } phone_e;

  localparam int unsigned WIN_DEPTH = 4;
  localparam int unsigned STEP_MAX  = 4;   // tokens one byte can release
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] pat;     // first byte in the top byte
    logic [1:0]  nemit;
    phone_e      first;
    phone_e      second;
  } phone_rule_t;

  typedef struct packed {
    logic [5:0] code;
    logic       valid;
    logic       done;
  } phone_result_t;

  phone_rule_t   rule_tab [$];
  phone_result_t token_q [$];
  logic [7:0]    win [WIN_DEPTH];
  int unsigned   win_cnt;
  int unsigned   step_tokens;
  int            mismatches, tokens_seen, markers_seen, texts_seen;

  task automatic add_rule(input int len, input logic [31:0] pat, input int n,
                          input phone_e a, input phone_e b);
    phone_rule_t rl;
    rl.len    = 3'(len);
    rl.pat    = pat;
    rl.nemit  = 2'(n);
    rl.first  = a;
    rl.second = b;
    rule_tab.push_back(rl);
  endtask

  // priority order matters: diphthongs and affricates ahead of their parts
  initial begin
    add_rule(3, 32'h65C9AA00, 2, PH_E,       PH_I_LAX);
    add_rule(4, 32'hC991C9AA, 2, PH_A_BACK,  PH_I_LAX);
    add_rule(3, 32'h61C9AA00, 2, PH_A_BACK,  PH_I_LAX);
    add_rule(4, 32'hC991CA8A, 2, PH_A_BACK,  PH_U_LAX);
    add_rule(3, 32'h61CA8A00, 2, PH_A_BACK,  PH_U_LAX);
    add_rule(4, 32'hC994C9AA, 2, PH_O_OPEN,  PH_I_LAX);
    add_rule(3, 32'h6FCA8A00, 2, PH_O,       PH_U_LAX);
    add_rule(4, 32'hC999CA8A, 2, PH_O,       PH_U_LAX);
    add_rule(3, 32'h74CA8300, 2, PH_T,       PH_SH);
    add_rule(3, 32'h64CA9200, 2, PH_D,       PH_ZH);
    add_rule(2, 32'hCB900000, 0, PH_E,       PH_E);      // length mark, dropped
    add_rule(2, 32'hCB880000, 1, PH_STRESS1, PH_E);
    add_rule(2, 32'hCB8C0000, 1, PH_STRESS2, PH_E);
    add_rule(2, 32'hC9A10000, 1, PH_G,       PH_E);
    add_rule(2, 32'hC99A0000, 1, PH_ER,      PH_E);
    add_rule(2, 32'hC9980000, 1, PH_SCHWA,   PH_E);
    add_rule(2, 32'hC9900000, 1, PH_WEDGE,   PH_E);
    add_rule(2, 32'hC99C0000, 1, PH_ER,      PH_E);
    add_rule(2, 32'hC9920000, 1, PH_O_OPEN,  PH_E);
    add_rule(2, 32'hC9BE0000, 1, PH_D,       PH_E);
    add_rule(2, 32'hC9AA0000, 1, PH_I_LAX,   PH_E);
    add_rule(2, 32'hC99B0000, 1, PH_EPS,     PH_E);
    add_rule(2, 32'hC3A60000, 1, PH_ASH,     PH_E);
    add_rule(2, 32'hC9910000, 1, PH_A_BACK,  PH_E);
    add_rule(2, 32'hC9940000, 1, PH_O_OPEN,  PH_E);
    add_rule(2, 32'hCA8A0000, 1, PH_U_LAX,   PH_E);
    add_rule(2, 32'hCA8C0000, 1, PH_WEDGE,   PH_E);
    add_rule(2, 32'hC99D0000, 1, PH_ER,      PH_E);
    add_rule(2, 32'hC9990000, 1, PH_SCHWA,   PH_E);
    add_rule(2, 32'hC58B0000, 1, PH_NG,      PH_E);
    add_rule(2, 32'hCEB80000, 1, PH_TH,      PH_E);
    add_rule(2, 32'hC3B00000, 1, PH_DH,      PH_E);
    add_rule(2, 32'hCA830000, 1, PH_SH,      PH_E);
    add_rule(2, 32'hCA920000, 1, PH_ZH,      PH_E);
    add_rule(2, 32'hC9B90000, 1, PH_R,       PH_E);
    add_rule(1, 32'h61000000, 1, PH_A_BACK,  PH_E);
    add_rule(1, 32'h72000000, 1, PH_R,       PH_E);
    add_rule(1, 32'h79000000, 1, PH_J,       PH_E);
    add_rule(1, 32'h67000000, 1, PH_G,       PH_E);
    add_rule(1, 32'h20000000, 1, PH_PAUSE,   PH_E);
    add_rule(1, 32'h09000000, 1, PH_PAUSE,   PH_E);
    add_rule(1, 32'h0A000000, 1, PH_PAUSE,   PH_E);
  end

  function automatic logic ascii_phone(input logic [7:0] b, output logic [5:0] code);
    logic hit;
    hit = 1'b1;
    case (b)
      8'h69:   code = PH_I;
      8'h65:   code = PH_E;
      8'h6F:   code = PH_O;
      8'h75:   code = PH_U;
      8'h70:   code = PH_P;
      8'h62:   code = PH_B;
      8'h74:   code = PH_T;
      8'h64:   code = PH_D;
      8'h6B:   code = PH_K;
      8'h6D:   code = PH_M;
      8'h6E:   code = PH_N;
      8'h66:   code = PH_F;
      8'h76:   code = PH_V;
      8'h73:   code = PH_S;
      8'h7A:   code = PH_Z;
      8'h68:   code = PH_H;
      8'h77:   code = PH_W;
      8'h6A:   code = PH_J;
      8'h6C:   code = PH_L;
      default: begin
        hit  = 1'b0;
        code = '0;
      end
    endcase
    return hit;
  endfunction

  // bytes covered by a UTF-8 lead; stray continuations and 0xF8+ count as one
  function automatic int unsigned utf8_span(input logic [7:0] lead);
    int unsigned n;
    if (!lead[7])                      n = 1;
    else if ((lead & 8'hE0) == 8'hC0)  n = 2;
    else if ((lead & 8'hF0) == 8'hE0)  n = 3;
    else if ((lead & 8'hF8) == 8'hF0)  n = 4;
    else                               n = 1;
    return n;
  endfunction

  task automatic emit_phone(input logic [5:0] code);
    phone_result_t r;
    if (step_tokens < STEP_MAX) begin
      r.code  = code;
      r.valid = 1'b1;
      r.done  = 1'b0;
      token_q.push_back(r);
      step_tokens++;
    end
  endtask

  // one decision at the window head; only the held bytes take part
  task automatic decide_head();
    int unsigned take;
    logic        hit;
    logic [5:0]  dcode;
    phone_rule_t rl;
    take = 0;
    for (int r = 0; r < rule_tab.size() && take == 0; r++) begin
      rl  = rule_tab[r];
      hit = (rl.len <= win_cnt);
      for (int k = 0; k < WIN_DEPTH; k++)
        if (hit && k < rl.len && win[k] != rl.pat[31-8*k -: 8]) hit = 1'b0;
      if (hit) begin
        if (rl.nemit > 0) emit_phone(rl.first);
        if (rl.nemit > 1) emit_phone(rl.second);
        take = rl.len;
      end
    end
    if (take == 0) begin
      if (ascii_phone(win[0], dcode)) begin
        emit_phone(dcode);
        take = 1;
      end else begin
        take = utf8_span(win[0]);
      end
    end
    if (take > win_cnt) take = win_cnt;
    for (int k = 0; k + take < WIN_DEPTH; k++) win[k] = win[k+take];
    win_cnt -= take;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    phone_result_t r;
    step_tokens = 0;
    if (win_cnt < WIN_DEPTH) begin
      win[win_cnt] = b;
      win_cnt++;
    end
    if (!last) begin
      if (win_cnt == WIN_DEPTH) decide_head();
    end else begin
      while (win_cnt > 0) decide_head();
      if (step_tokens == 0) begin
        r.code  = '0;
        r.valid = 1'b0;
        r.done  = 1'b1;
        token_q.push_back(r);
      end else begin
        r = token_q[token_q.size()-1];
        token_q.pop_back();
        r.done = 1'b1;
        token_q.push_back(r);
      end
      win_cnt = 0;
      texts_seen++;
    end
  endtask

  task automatic report(input string what, input phone_result_t want, input phone_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected code %0d valid %0b done %0b, got code %0d valid %0b done %0b",
               $realtime, what, want.code, want.valid, want.done,
               got.code, got.valid, got.done);
  endtask

  task automatic check_result();
    phone_result_t want, got;
    got.code  = phone_code_o;
    got.valid = phone_valid_o;
    got.done  = text_done_o;
    if (token_q.size() == 0) begin
      report("result with nothing pending", '0, got);
    end else begin
      want = token_q.pop_front();
      if (want.code !== got.code || want.valid !== got.valid || want.done !== got.done)
        report("token mismatch", want, got);
      else if (want.valid)
        tokens_seen++;
      else
        markers_seen++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cnt      = 0;
      token_q.delete();
      mismatches   = 0;
      tokens_seen  = 0;
      markers_seen = 0;
      texts_seen   = 0;
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) predict_byte(text_byte_i, text_end_i);
    end
    pending_o    <= token_q.size();
    fail_count_o <= mismatches + token_q.size() * int'(0);
    tokens_o     <= tokens_seen;
    markers_o    <= markers_seen;
    texts_o      <= texts_seen;
  end

endmodule

>>> test/ipa_phone_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPA phone tokenizer testbench
// Feeds directed and random UTF-8 IPA strings into the tokenizer with random
// gaps on both sides; the checker beside the DUT predicts and compares tokens.
// ----------------------------------------------------------------------------
module ipa_phone_tokenizer_top_tb;

  localparam int ITEMS       = 320;   // bytes sent in all, directed ones included, roughly
  localparam int QUIET_TAIL  = 60;    // last bytes sent without any gaps
  localparam int IDLE_LIMIT  = 500;   // cycles with no request moving
  localparam int TAIL_CYCLES = 12;    // settle time after the last token

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       push;
  logic                       full;
  logic [7:0]                 text_byte_i;
  logic                       text_end_i;
  logic                       empty;
  logic                       pop;
  logic [ipt_pkg::CODE_W-1:0] phone_code_o;
  logic                       phone_valid_o;
  logic                       text_done_o;

  int pending, fail_count, tokens, markers, texts;

  // Stimulus side state
  logic [7:0]  text_q [$];
  int          bytes_sent = 0;
  logic        quiet      = 1'b0;   // no gaps on either side once set
  logic        byte_gaps  = 1'b1;   // per string: sender may idle or not

  // Receiver side state
  int unsigned pop_hold  = 0;
  logic        pop_gaps  = 1'b1;
  int          idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ipa_phone_tokenizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte_i),
    .text_end_i    (text_end_i),
    .empty         (empty),
    .pop           (pop),
    .phone_code_o  (phone_code_o),
    .phone_valid_o (phone_valid_o),
    .text_done_o   (text_done_o)
  );

  ipa_phone_tokenizer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte_i),
    .text_end_i    (text_end_i),
    .empty         (empty),
    .pop           (pop),
    .phone_code_o  (phone_code_o),
    .phone_valid_o (phone_valid_o),
    .text_done_o   (text_done_o),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .tokens_o      (tokens),
    .markers_o     (markers),
    .texts_o       (texts)
  );

  // --------------------------------------------------------------------------
  // Byte requests
  // --------------------------------------------------------------------------

  // Holds one byte request until the DUT takes it. full is read in the active
  // region of the edge, so it is the value the DUT itself saw at that edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    push        <= 1'b1;
    text_byte_i <= b;
    text_end_i  <= last;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  task automatic idle_push(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Lowers push and waits until every predicted token has been popped.
  task automatic drain_wait();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Sends the queued string; the last byte carries the end flag, which
  // flushes the window in the DUT.
  task automatic play_text();
    byte_gaps = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < text_q.size(); i++) begin
      if (!quiet && byte_gaps && $urandom_range(0, 4) == 0)
        idle_push($urandom_range(1, 3));
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  // Directed strings are packed with the first byte highest.
  task automatic load_word(input logic [95:0] w, input int n);
    for (int i = n - 1; i >= 0; i--) text_q.push_back(w[8*i +: 8]);
  endtask

  // --------------------------------------------------------------------------
  // Random text pieces
  // --------------------------------------------------------------------------

  // ASCII: phone letters, rule letters, pause characters and a few that
  // fall through to the UTF-8 skip.
  function automatic logic [7:0] ascii_pick();
    string s;
    s = "aeioupbtdkmnfvszhwjlrygxcq \t\n";
    return s.getc($urandom_range(0, s.len() - 1));
  endfunction

  // Two-byte IPA letters and marks that the rule table knows.
  function automatic logic [15:0] ipa_pick();
    logic [15:0] w;
    case ($urandom_range(0, 24))
      0:  w = 16'hC991;   1:  w = 16'hC9AA;   2:  w = 16'hC994;   3:  w = 16'hC999;
      4:  w = 16'hC9A1;   5:  w = 16'hC99A;   6:  w = 16'hC998;   7:  w = 16'hC990;
      8:  w = 16'hC99C;   9:  w = 16'hC992;   10: w = 16'hC9BE;   11: w = 16'hC99B;
      12: w = 16'hC9B9;   13: w = 16'hC99D;   14: w = 16'hCA8A;   15: w = 16'hCA83;
      16: w = 16'hCA92;   17: w = 16'hCA8C;   18: w = 16'hCB90;   19: w = 16'hCB88;
      20: w = 16'hCB8C;   21: w = 16'hC3A6;   22: w = 16'hC3B0;   23: w = 16'hC58B;
      default: w = 16'hCEB8;
    endcase
    return w;
  endfunction

  task automatic add_piece();
    int          kind;
    int          n;
    logic [15:0] w;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      text_q.push_back(ascii_pick());
    end else if (kind < 65) begin
      w = ipa_pick();
      text_q.push_back(w[15:8]);
      text_q.push_back(w[7:0]);
    end else if (kind < 77) begin
      // diphthong and affricate openers followed by a glide or fricative,
      // so the three- and four-byte rules get exercised
      case ($urandom_range(0, 7))
        0: text_q.push_back(8'h65);
        1: text_q.push_back(8'h61);
        2: text_q.push_back(8'h6F);
        3: text_q.push_back(8'h74);
        4: text_q.push_back(8'h64);
        5: begin text_q.push_back(8'hC9); text_q.push_back(8'h91); end
        6: begin text_q.push_back(8'hC9); text_q.push_back(8'h94); end
        default: begin text_q.push_back(8'hC9); text_q.push_back(8'h99); end
      endcase
      case ($urandom_range(0, 3))
        0: w = 16'hC9AA;
        1: w = 16'hCA8A;
        2: w = 16'hCA83;
        default: w = 16'hCA92;
      endcase
      text_q.push_back(w[15:8]);
      text_q.push_back(w[7:0]);
    end else if (kind < 88) begin
      // well-formed UTF-8 of any length with random payload
      n = $urandom_range(1, 4);
      case (n)
        1: text_q.push_back(8'($urandom_range(0, 127)));
        2: text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        3: text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        default: text_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
      endcase
      for (int i = 1; i < n; i++) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end else begin
      // noise: any byte, stray continuations and invalid leads included
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: pops with random stall bursts, switching between stalling
  // and stall-free stretches; never stalls in the tail.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if (!quiet && pop_gaps && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(0, 2);
    end else begin
      pop <= 1'b1;
    end
    if ($urandom_range(0, 49) == 0) pop_gaps = ~pop_gaps;
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long run of cycles with no request moving either way means
  // the DUT has hung.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic paused;
    paused = 1'b0;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    text_byte_i <= 8'h00;
    text_end_i  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings
    load_word(96'h00, 1);             // lowest byte alone: end marker only
    play_text();
    load_word(96'hFF, 1);             // highest byte, invalid lead: end marker
    play_text();
    // four-byte diphthong, affricate, stray continuation, invalid lead, then
    // a diphthong cut short by the end: it may not match past the last byte,
    // and the two-byte lead that is left is skipped only as far as it goes
    load_word(96'hC991C9AA_74CA83_80_F8_65C9, 11);
    play_text();
    load_word(96'hE282, 2);           // three-byte lead truncated by the end
    play_text();
    load_word(96'hF09F9880_6C, 5);    // four-byte skip, then a direct letter
    play_text();
    load_word(96'hCB90, 2);           // length mark only: no token, end marker
    play_text();

    // Random strings of 1 to 8 pieces
    while (bytes_sent < ITEMS) begin
      if (bytes_sent >= ITEMS - QUIET_TAIL) quiet <= 1'b1;
      repeat ($urandom_range(1, 8)) add_piece();
      play_text();
      // once mid-run, hold off until the DUT has given every token back
      if (!paused && bytes_sent >= ITEMS / 2) begin
        drain_wait();
        paused = 1'b1;
      end
    end

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d bytes in %0d strings: %0d tokens and %0d end markers checked",
             bytes_sent, texts, tokens, markers);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d tokens never seen", fail_count, pending);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ipt_pkg.sv
hw/rtl/ipt_fifo.sv
hw/rtl/ipt_front.sv
hw/rtl/ipt_back.sv
hw/rtl/ipa_phone_tokenizer_top.sv
test/ipa_phone_tokenizer_checker.sv
test/ipa_phone_tokenizer_top_tb.sv
